>>> rtl/tdq_pkg.sv
// ----------------------------------------------------------------------------
// Triangular dither quantizer package
// Shared widths, hash constants, pipeline depth and the stage control type.
// ----------------------------------------------------------------------------
package tdq_pkg;

	// Field widths fixed by the pixel and level formats.
	localparam int PIX_W    = 16;
	localparam int CELL_W   = 32;
	localparam int LEVEL_W  = 16;
	localparam int CFG_W    = 5;
	localparam int PROD_W   = 2 * PIX_W;
	localparam int HASH_W   = 32;
	localparam int UNIF_W   = 24;

	// One lane for each color channel.
	localparam int NUM_LANES  = 3;
	// Register stages inside one lane.
	localparam int NUM_STAGES = 7;

	// Level bit settings.
	localparam logic [CFG_W-1:0] BITS_RESET   = 5'd8;
	localparam logic [CFG_W-1:0] BITS_DEFAULT = 5'd8;
	localparam logic [CFG_W-1:0] BITS_MAX     = 5'd16;

	// Hash and seed constants.
	localparam logic [HASH_W-1:0] SEED_MUL  = 32'd2654435761;
	localparam logic [HASH_W-1:0] SEED_XOR  = 32'h9e37_79b9;
	localparam logic [HASH_W-1:0] HASH_MUL1 = 32'h7feb_352d;
	localparam logic [HASH_W-1:0] HASH_MUL2 = 32'h846c_a68b;

	typedef logic [PIX_W-1:0]   pix_t;
	typedef logic [CELL_W-1:0]  cell_t;
	typedef logic [LEVEL_W-1:0] level_t;
	typedef logic [CFG_W-1:0]   cfg_t;
	typedef logic [HASH_W-1:0]  hash_t;

	// Per-stage load enables handed from the pipeline control to the lanes.
	typedef struct packed {
		logic [NUM_STAGES-1:0] en;
	} pipe_ctrl_t;

endpackage

>>> rtl/tdq_if.sv
// ----------------------------------------------------------------------------
// Triangular dither quantizer channel interfaces
// Valid/ready channels for input pixels and output level codes.
// ----------------------------------------------------------------------------
interface tdq_pixel_if;
	import tdq_pkg::*;

	logic  valid;
	logic  ready;
	pix_t  red_in;
	pix_t  green_in;
	pix_t  blue_in;
	cell_t cell_index;

	modport source (output valid, output red_in, output green_in, output blue_in,
		output cell_index, input ready);
	modport sink (input valid, input red_in, input green_in, input blue_in,
		input cell_index, output ready);
endinterface

interface tdq_level_if;
	import tdq_pkg::*;

	logic   valid;
	logic   ready;
	level_t red_level;
	level_t green_level;
	level_t blue_level;

	modport source (output valid, output red_level, output green_level,
		output blue_level, input ready);
	modport sink (input valid, input red_level, input green_level,
		input blue_level, output ready);
endinterface

>>> rtl/tdq_lane.sv
// ----------------------------------------------------------------------------
// Triangular dither quantizer lane
// Seven-stage datapath for one color channel: seed hashing into two uniforms,
// exact division of value*levels by the channel full scale, dither add,
// rounding and clamping to the level range.
// ----------------------------------------------------------------------------
module tdq_lane #(
	parameter int CHANNEL_BITS = 16
) (
	input  logic                clk,
	input  tdq_pkg::pipe_ctrl_t ctrl,
	input  tdq_pkg::pix_t       chan,
	input  tdq_pkg::hash_t      seed_base,
	input  tdq_pkg::level_t     levels,
	output tdq_pkg::level_t     level
);
	import tdq_pkg::*;

	localparam int K      = CHANNEL_BITS;
	// Number of K-bit shifted terms for the quotient estimate.
	localparam int NTERM  = (PROD_W + K - 1) / K;
	localparam int R0_W   = K + 3;
	localparam int N_W    = UNIF_W + 3;
	localparam int SW     = K + 28;
	localparam logic [K:0]         FULL_SCALE = (K+1)'((64'd1 << K) - 64'd1);
	localparam logic [N_W-1:0]     NOISE_BIAS = N_W'(64'd1 << (UNIF_W - 1));
	localparam logic signed [SW-1:0] DEN1 = SW'((64'd1 << K) - 64'd1) << UNIF_W;
	localparam logic signed [SW-1:0] DEN2 = DEN1 <<< 1;

	// Stage registers.
	hash_t                 seed_s1;
	logic [PROD_W-1:0]     prod_s1;
	hash_t                 h0_s2, h1_s2;
	logic [PROD_W-1:0]     prod_s2;
	logic [PROD_W-1:0]     q0_s2;
	hash_t                 h0_s3, h1_s3;
	logic [PROD_W-1:0]     q0_s3;
	logic [R0_W-1:0]       r0_s3;
	logic signed [N_W-1:0] n_s4;
	logic [PROD_W-1:0]     q1_s4;
	logic [K-1:0]          r1_s4;
	logic signed [SW-1:0]  s0_s5;
	logic [PROD_W-1:0]     q1_s5;
	logic [1:0]            cnt_s6;
	logic [PROD_W-1:0]     q1_s6;
	level_t                level_s7;

	// Combinational values between stages.
	hash_t                 x0_a, x1_a, x0_b, x1_b, x0_c, x1_c;
	logic [PROD_W-1:0]     q0_est;
	logic [UNIF_W-1:0]     u0, u1;
	logic [2:0]            hi;
	logic [K:0]            fold;
	logic [PROD_W+1:0]     code_p1;

	// Stage 1: seed multiply and value times level count.
	always_ff @(posedge clk) begin
		if (ctrl.en[0]) begin
			seed_s1 <= HASH_W'(seed_base * SEED_MUL);
			prod_s1 <= PROD_W'(PROD_W'(chan) * PROD_W'(levels));
		end
	end

	// Stage 2: first hash round and quotient estimate by the series 1/(2^K-1).
	always_comb begin
		x0_a = seed_s1 ^ (seed_s1 >> 16);
		x1_a = (seed_s1 ^ SEED_XOR) ^ ((seed_s1 ^ SEED_XOR) >> 16);
		q0_est = '0;
		for (int i = 1; i <= NTERM; i++) begin
			q0_est = q0_est + (prod_s1 >> (i * K));
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[1]) begin
			h0_s2   <= HASH_W'(x0_a * HASH_MUL1);
			h1_s2   <= HASH_W'(x1_a * HASH_MUL1);
			prod_s2 <= prod_s1;
			q0_s2   <= q0_est;
		end
	end

	// Stage 3: second hash round and the remainder left by the estimate.
	always_comb begin
		x0_b = h0_s2 ^ (h0_s2 >> 15);
		x1_b = h1_s2 ^ (h1_s2 >> 15);
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[2]) begin
			h0_s3 <= HASH_W'(x0_b * HASH_MUL2);
			h1_s3 <= HASH_W'(x1_b * HASH_MUL2);
			q0_s3 <= q0_s2;
			r0_s3 <= R0_W'(prod_s2 + q0_s2 - (q0_s2 << K));
		end
	end

	// Stage 4: final hash shift into uniforms, noise sum, remainder folding.
	always_comb begin
		x0_c = h0_s3 ^ (h0_s3 >> 16);
		x1_c = h1_s3 ^ (h1_s3 >> 16);
		u0   = x0_c[HASH_W-1 -: UNIF_W];
		u1   = x1_c[HASH_W-1 -: UNIF_W];
		hi   = r0_s3[R0_W-1 -: 3];
		fold = {1'b0, r0_s3[K-1:0]} + (K+1)'(hi);
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[3]) begin
			n_s4 <= $signed(N_W'(u0) + N_W'(u1) - NOISE_BIAS);
			if (fold >= FULL_SCALE) begin
				r1_s4 <= K'(fold - FULL_SCALE);
				q1_s4 <= q0_s3 + PROD_W'(hi) + PROD_W'(1);
			end else begin
				r1_s4 <= K'(fold);
				q1_s4 <= q0_s3 + PROD_W'(hi);
			end
		end
	end

	// Stage 5: remainder scaled by 2^24 plus noise times the full scale.
	always_ff @(posedge clk) begin
		if (ctrl.en[4]) begin
			s0_s5 <= $signed((SW'(r1_s4) << UNIF_W) + (SW'(n_s4) << K) - SW'(n_s4));
			q1_s5 <= q1_s4;
		end
	end

	// Stage 6: the fractional part lands in one of four unit intervals.
	always_ff @(posedge clk) begin
		if (ctrl.en[5]) begin
			cnt_s6 <= 2'(s0_s5 >= 0) + 2'(s0_s5 >= DEN1) + 2'(s0_s5 >= DEN2);
			q1_s6  <= q1_s5;
		end
	end

	// Stage 7: code plus one, then clamp to the level range.
	assign code_p1 = (PROD_W+2)'(q1_s6) + (PROD_W+2)'(cnt_s6);

	always_ff @(posedge clk) begin
		if (ctrl.en[6]) begin
			if (code_p1 == '0) begin
				level_s7 <= '0;
			end else if (code_p1 > (PROD_W+2)'(levels) + (PROD_W+2)'(1)) begin
				level_s7 <= levels;
			end else begin
				level_s7 <= LEVEL_W'(code_p1 - (PROD_W+2)'(1));
			end
		end
	end

	assign level = level_s7;

endmodule

>>> rtl/tdq_merge.sv
// ----------------------------------------------------------------------------
// Triangular dither quantizer merge stage
// Gathers the three lane codes into one output transaction and holds it in
// the output register until the consumer takes it.
// ----------------------------------------------------------------------------
module tdq_merge (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            lane_valid,
	input  tdq_pkg::level_t lane_level [tdq_pkg::NUM_LANES],
	output logic            take,
	tdq_level_if.source     result
);
	import tdq_pkg::*;

	logic   out_valid_q;
	level_t level_q [NUM_LANES];

	// The output register loads whenever it is empty or being drained.
	assign take = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= lane_valid;
		end
	end

	// Payload captures only real transactions.
	always_ff @(posedge clk) begin
		if (take && lane_valid) begin
			level_q <= lane_level;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.red_level   = level_q[0];
	assign result.green_level = level_q[1];
	assign result.blue_level  = level_q[2];

endmodule

>>> rtl/triangular_dither_quantizer_core.sv
// ----------------------------------------------------------------------------
// Triangular dither quantizer core
// Adds hashed triangular noise to each RGB channel and rounds it to the
// nearest level code in 0 to 2^bits-1, three channel lanes side by side.
//
//   Channel   Direction  Handshake      Payload
//   pixel     in         valid/ready    red_in, green_in, blue_in, cell_index
//   result    out        valid/ready    red_level, green_level, blue_level
//   cfg       in         cfg_we         cfg_wdata (level bits, 0 selects 8)
//
// One pixel is accepted per clock while pixel.ready is high; after acceptance
// the pixel passes 7 lane stages, then the merge register.
// Stalls are per stage: an empty stage keeps loading while the output waits.
// Reset clears the stage valid bits, the output valid and sets level bits to 8.
// ----------------------------------------------------------------------------
module triangular_dither_quantizer_core #(
	parameter int CHANNEL_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  tdq_pkg::cfg_t cfg_wdata,
	tdq_pixel_if.sink     pixel,
	tdq_level_if.source   result
);
	import tdq_pkg::*;

	cfg_t                  level_bits_q;
	cfg_t                  eff_bits;
	level_t                levels;
	logic [NUM_STAGES-1:0] valid_q;
	logic [NUM_STAGES-1:0] en;
	logic                  take;
	pipe_ctrl_t            ctrl;
	hash_t                 cell3;
	hash_t                 seed_base [NUM_LANES];
	pix_t                  chan [NUM_LANES];
	level_t                lane_level [NUM_LANES];

	// Level bits register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_bits_q <= BITS_RESET;
		end else if (cfg_we) begin
			level_bits_q <= cfg_wdata;
		end
	end

	// Effective bit count and the top level code.
	always_comb begin
		if (level_bits_q == '0) begin
			eff_bits = BITS_DEFAULT;
		end else if (level_bits_q > BITS_MAX) begin
			eff_bits = BITS_MAX;
		end else begin
			eff_bits = level_bits_q;
		end
		levels = LEVEL_W'(((LEVEL_W+1)'(1) << eff_bits) - (LEVEL_W+1)'(1));
	end

	// Stage enables: a stage loads when it is empty or its successor loads.
	always_comb begin
		en[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || take;
		for (int i = NUM_STAGES - 2; i >= 0; i--) begin
			en[i] = !valid_q[i] || en[i+1];
		end
	end

	assign pixel.ready = en[0];
	assign ctrl.en     = en;

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[0]) begin
				valid_q[0] <= pixel.valid;
			end
			for (int i = 1; i < NUM_STAGES; i++) begin
				if (en[i]) begin
					valid_q[i] <= valid_q[i-1];
				end
			end
		end
	end

	// Per-channel seed base: cell*3 + channel number.
	assign cell3   = (pixel.cell_index << 1) + pixel.cell_index;
	assign chan[0] = pixel.red_in;
	assign chan[1] = pixel.green_in;
	assign chan[2] = pixel.blue_in;

	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		assign seed_base[g] = cell3 + HASH_W'(g);

		tdq_lane #(
			.CHANNEL_BITS(CHANNEL_BITS)
		) u_lane (
			.clk      (clk),
			.ctrl     (ctrl),
			.chan     (chan[g]),
			.seed_base(seed_base[g]),
			.levels   (levels),
			.level    (lane_level[g])
		);
	end

	// Merge the lane codes into the output register.
	tdq_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.lane_valid(valid_q[NUM_STAGES-1]),
		.lane_level(lane_level),
		.take      (take),
		.result    (result)
	);

endmodule

>>> dv/triangular_dither_quantizer_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Triangular dither quantizer core testbench
// Drives pixels through the valid/ready input channel and checks every level
// code on the result channel against an exact integer model of the hashed
// triangular dither and rounding. A directed table covers the field extremes
// and the level bit corner cases. Random phases follow, each with a level bit
// setting and one of four patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module triangular_dither_quantizer_core_tb;
	import tdq_pkg::*;

	localparam int CHANNEL_BITS = 16;
	localparam int NUM_DIRECTED = 20;
	localparam int NUM_PHASES   = 8;
	localparam int PHASE_ITEMS  = 113;
	localparam int DRAIN_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 250000;

	// Hash constants of the noise generator.
	localparam hash_t GOLDEN_MUL = 32'd2654435761;
	localparam hash_t SEED_FLIP  = 32'h9e37_79b9;
	localparam hash_t MIX_MUL_A  = 32'h7feb_352d;
	localparam hash_t MIX_MUL_B  = 32'h846c_a68b;

	typedef struct {
		cfg_t  bits;
		pix_t  red;
		pix_t  green;
		pix_t  blue;
		cell_t cell_id;
	} pixel_row_t;

	typedef struct {
		level_t red;
		level_t green;
		level_t blue;
	} level_set_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	cfg_t cfg_wdata;

	tdq_pixel_if pix_if ();
	tdq_level_if lvl_if ();

	triangular_dither_quantizer_core #(
		.CHANNEL_BITS(CHANNEL_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.pixel(pix_if),
		.result(lvl_if)
	);

	// Level codes still owed by the block, oldest first.
	level_set_t expected_levels[$];
	cfg_t level_bits_cfg;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned errors;
	int unsigned cycle_count;

	// Directed rows: reset setting, zero bits, one bit, full 16 bits, too many bits, two bits, 15 bits.
	pixel_row_t directed_rows [NUM_DIRECTED] = '{
		'{5'd8,  16'h0000, 16'h0000, 16'h0000, 32'h0000_0000},
		'{5'd8,  16'hffff, 16'hffff, 16'hffff, 32'hffff_ffff},
		'{5'd8,  16'h8000, 16'h0001, 16'hfffe, 32'h0000_0001},
		'{5'd8,  16'h5555, 16'haaaa, 16'h7fff, 32'h8000_0000},
		'{5'd0,  16'h0000, 16'hffff, 16'h7fff, 32'h0000_0007},
		'{5'd0,  16'hffff, 16'h0000, 16'h0001, 32'hffff_ffff},
		'{5'd1,  16'h0000, 16'h0000, 16'h0000, 32'h1234_5678},
		'{5'd1,  16'hffff, 16'hffff, 16'hffff, 32'h0000_0000},
		'{5'd1,  16'h7fff, 16'h8000, 16'h4000, 32'hc0de_f00d},
		'{5'd1,  16'h8000, 16'h7fff, 16'hc000, 32'h0000_0002},
		'{5'd16, 16'h0000, 16'hffff, 16'h0001, 32'h0000_0003},
		'{5'd16, 16'hfffe, 16'h0002, 16'h8000, 32'hffff_ffff},
		'{5'd16, 16'hffff, 16'h0000, 16'h7fff, 32'h5555_5555},
		'{5'd17, 16'h0000, 16'hffff, 16'h8000, 32'haaaa_aaaa},
		'{5'd17, 16'hffff, 16'h0001, 16'hfffe, 32'h0000_0000},
		'{5'd31, 16'h1234, 16'hedcb, 16'h8001, 32'h7fff_ffff},
		'{5'd31, 16'hffff, 16'h0000, 16'h0000, 32'h0000_0001},
		'{5'd2,  16'h0000, 16'h5555, 16'haaaa, 32'h0000_ffff},
		'{5'd2,  16'hffff, 16'h2aaa, 16'hd555, 32'hffff_0000},
		'{5'd15, 16'h0001, 16'hfffe, 16'h8000, 32'h0000_0004}
	};

	// Clock generation.
	always #5 clk = ~clk;

	// Xor-shift-multiply hash that feeds the uniform noise terms.
	function automatic hash_t scramble(hash_t h);
		h = h ^ (h >> 16);
		h = h * MIX_MUL_A;
		h = h ^ (h >> 15);
		h = h * MIX_MUL_B;
		h = h ^ (h >> 16);
		return h;
	endfunction

	// Highest level code for a setting: zero means 8 bits, at most 16 bits.
	function automatic int unsigned top_level(cfg_t bits);
		int unsigned width;
		width = bits;
		if (width == 0)
			width = 8;
		if (width > 16)
			width = 16;
		return (1 << width) - 1;
	endfunction

	// Exact floor(v*L/M + noise + 1/2), clamped to [0, L].
	function automatic level_t dithered_level(pix_t v, cell_t cell_id, int unsigned lane,
			int unsigned levels);
		hash_t  seed;
		longint u0, u1, half_noise, full_scale, prod, quot, rem, num, den, step, code;
		seed = (cell_id * 32'd3 + hash_t'(lane)) * GOLDEN_MUL;
		u0 = longint'(scramble(seed) >> 8);
		u1 = longint'(scramble(seed ^ SEED_FLIP) >> 8);
		half_noise = u0 + u1 - (longint'(1) << 24) + (longint'(1) << 23);
		full_scale = (longint'(1) << CHANNEL_BITS) - 1;
		prod = longint'(v) * longint'(levels);
		quot = prod / full_scale;
		rem = prod % full_scale;
		num = (rem << 24) + half_noise * full_scale;
		den = full_scale << 24;
		if (num >= 0)
			step = num / den;
		else
			step = -((-num + den - 1) / den);
		code = quot + step;
		if (code < 0)
			code = 0;
		if (code > longint'(levels))
			code = longint'(levels);
		return level_t'(code);
	endfunction

	function automatic level_set_t predict_levels(pixel_row_t p, cfg_t bits);
		level_set_t res;
		int unsigned levels;
		levels = top_level(bits);
		res.red   = dithered_level(p.red,   p.cell_id, 0, levels);
		res.green = dithered_level(p.green, p.cell_id, 1, levels);
		res.blue  = dithered_level(p.blue,  p.cell_id, 2, levels);
		return res;
	endfunction

	// Channel values lean toward the ends of the range.
	function automatic pix_t random_channel();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return pix_t'($urandom_range(3));
			3: return pix_t'(16'hffff - $urandom_range(3));
			default: return pix_t'($urandom());
		endcase
	endfunction

	function automatic pixel_row_t random_pixel();
		pixel_row_t p;
		p.bits  = level_bits_cfg;
		p.red   = random_channel();
		p.green = random_channel();
		p.blue  = random_channel();
		case ($urandom_range(7))
			0: p.cell_id = cell_t'($urandom_range(15));
			1: p.cell_id = cell_t'(32'hffff_ffff - $urandom_range(15));
			default: p.cell_id = cell_t'($urandom());
		endcase
		return p;
	endfunction

	function automatic void check_field(string name, level_t want, level_t got);
		if (want !== got) begin
			$display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	// Offer one pixel, with random gaps first, and hold it until the transaction.
	task automatic send_pixel(pixel_row_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			pix_if.valid <= 1'b0;
			@(posedge clk);
		end
		pix_if.valid      <= 1'b1;
		pix_if.red_in     <= p.red;
		pix_if.green_in   <= p.green;
		pix_if.blue_in    <= p.blue;
		pix_if.cell_index <= p.cell_id;
		do begin
			@(posedge clk);
		end while (!pix_if.ready);
		expected_levels.push_back(predict_levels(p, level_bits_cfg));
	endtask

	// Stop sending and wait until every owed result has come out.
	task automatic wait_for_drain();
		pix_if.valid <= 1'b0;
		while (expected_levels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_level_bits(cfg_t value);
		wait_for_drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		level_bits_cfg = value;
	endtask

	// Receiver stalls at the rate of the current phase.
	always @(posedge clk) begin
		lvl_if.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Compare each result transaction with the oldest prediction.
	always @(posedge clk) begin
		level_set_t want;
		if (arst_n && lvl_if.valid && lvl_if.ready) begin
			if (expected_levels.size() == 0) begin
				$display("%0t unexpected result: actual %0d %0d %0d", $time,
					lvl_if.red_level, lvl_if.green_level, lvl_if.blue_level);
				errors++;
			end else begin
				want = expected_levels.pop_front();
				check_field("red_level",   want.red,   lvl_if.red_level);
				check_field("green_level", want.green, lvl_if.green_level);
				check_field("blue_level",  want.blue,  lvl_if.blue_level);
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		int unsigned phase_send [4];
		int unsigned phase_recv [4];
		cfg_t phase_bits [NUM_PHASES];
		phase_send        = '{0, 87, 0, 9};
		phase_recv        = '{0, 0, 87, 9};
		phase_bits        = '{5'd8, 5'd31, 5'd3, 5'd16, 5'd0, 5'd1, 5'd17, 5'd0};
		errors            = 0;
		cycle_count       = 0;
		send_idle_pct     = 0;
		recv_stall_pct    = 0;
		level_bits_cfg    = BITS_RESET;
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = '0;
		pix_if.valid      = 1'b0;
		pix_if.red_in     = '0;
		pix_if.green_in   = '0;
		pix_if.blue_in    = '0;
		pix_if.cell_index = '0;
		lvl_if.ready      = 1'b0;
		phase_bits[NUM_PHASES-1] = cfg_t'($urandom_range(31));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, each row checked against the predictor.
		foreach (directed_rows[i]) begin
			if (directed_rows[i].bits != level_bits_cfg)
				write_level_bits(directed_rows[i].bits);
			send_pixel(directed_rows[i]);
		end

		// Random phases, cycling through the idle patterns.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			write_level_bits(phase_bits[ph]);
			send_idle_pct  = phase_send[ph % 4];
			recv_stall_pct = phase_recv[ph % 4];
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Once, let the pipeline empty completely mid-phase.
				if (ph == 2 && n == PHASE_ITEMS / 2)
					wait_for_drain();
				send_pixel(random_pixel());
			end
		end

		wait_for_drain();
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
